@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh: concurrent assertion helpers, sampled on clk with the
// check held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/nih_pkg.sv @@
// ----------------------------------------------------------------------------
// nih_pkg: shared types for the integer hypotenuse block
// Controller states, datapath command and status bundles, divider constants.
// ----------------------------------------------------------------------------
package nih_pkg;

  localparam int unsigned DIV_BITS  = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ADD,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_DONE
  } nih_state_t;

  typedef struct packed {
    logic load;
    logic mul_x;
    logic mul_y;
    logic add;
    logic zero;
    logic fail;
    logic div_start;
    logic div_step;
    logic update;
  } nih_cmd_t;

  typedef struct packed {
    logic sq_zero;
    logic est_zero;
    logic div_last;
    logic converged;
  } nih_sts_t;

endpackage

@@ hw/rtl/nih_if.sv @@
// ----------------------------------------------------------------------------
// nih_in_if / nih_out_if: valid-ready channels of the hypotenuse block
// A transaction moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface nih_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;

  modport source (output valid, output offset_x, output offset_y, input ready);
  modport sink   (input valid, input offset_x, input offset_y, output ready);
endinterface

interface nih_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] length;
  logic               failed;

  modport source (output valid, output length, output failed, input ready);
  modport sink   (input valid, input length, input failed, output ready);
endinterface

@@ hw/rtl/nih_dp.sv @@
// ----------------------------------------------------------------------------
// nih_dp: hypotenuse datapath
// Shared squarer, square-sum register, bit-serial restoring divider and the
// Newton update of the 16-bit estimate.
// ----------------------------------------------------------------------------
module nih_dp (
  input  logic               clk,
  input  logic signed [15:0] offset_x,
  input  logic signed [15:0] offset_y,
  input  nih_pkg::nih_cmd_t  cmd,
  output nih_pkg::nih_sts_t  sts,
  output logic signed [15:0] length,
  output logic               failed
);

  logic signed [15:0] x_r, y_r, est_r;
  logic [31:0] prod_r, sq_r, dvd_r;
  logic [15:0] rem_r, dsr_r;
  logic        neg_r, fail_r;
  logic [nih_pkg::DIV_CNT_W-1:0] bit_cnt_r;

  logic signed [15:0] mul_op;
  logic [15:0] abs_x, abs_y;
  logic [16:0] shifted, diff;
  logic        ge;
  logic [15:0] q16, sum16, adj16;
  logic signed [15:0] half;

  assign mul_op = cmd.mul_y ? y_r : x_r;
  assign abs_x  = offset_x[15] ? 16'(-offset_x) : offset_x;
  assign abs_y  = offset_y[15] ? 16'(-offset_y) : offset_y;

  // one quotient bit per cycle
  assign shifted = {rem_r, dvd_r[31]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  // only the low 16 quotient bits reach the estimate
  assign q16   = neg_r ? 16'(-dvd_r[15:0]) : dvd_r[15:0];
  assign sum16 = est_r + q16;
  assign adj16 = sum16 + {15'd0, sum16[15]};   // halve toward zero
  assign half  = {adj16[15], adj16[15:1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= offset_x;
      y_r    <= offset_y;
      est_r  <= abs_x + abs_y;
      fail_r <= 1'b0;
    end
    if (cmd.mul_x || cmd.mul_y) begin
      prod_r <= 32'(mul_op * mul_op);
    end
    if (cmd.mul_y) begin
      sq_r <= prod_r;
    end
    if (cmd.add) begin
      sq_r <= sq_r + prod_r;
    end
    if (cmd.zero) begin
      est_r <= '0;
    end
    if (cmd.fail) begin
      est_r  <= '0;
      fail_r <= 1'b1;
    end
    if (cmd.div_start) begin
      dvd_r     <= sq_r[31] ? 32'(-sq_r) : sq_r;
      dsr_r     <= est_r[15] ? 16'(-est_r) : est_r;
      neg_r     <= sq_r[31] ^ est_r[15];
      rem_r     <= '0;
      bit_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= ge ? diff[15:0] : shifted[15:0];
      dvd_r     <= {dvd_r[30:0], ge};
      bit_cnt_r <= bit_cnt_r + 1'b1;
    end
    if (cmd.update) begin
      est_r <= half;
    end
  end

  assign sts.sq_zero   = (sq_r == '0);
  assign sts.est_zero  = (est_r == '0);
  assign sts.div_last  = (bit_cnt_r == nih_pkg::DIV_CNT_W'(nih_pkg::DIV_BITS - 1));
  assign sts.converged = (half == est_r);

  assign length = est_r;
  assign failed = fail_r;

endmodule

@@ hw/rtl/nih_ctrl.sv @@
// ----------------------------------------------------------------------------
// nih_ctrl: hypotenuse controller
// Sequences squaring, the per-step division and update, and the handshakes.
// ----------------------------------------------------------------------------
module nih_ctrl #(
  parameter int unsigned MAX_ITERATIONS = 100
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  nih_pkg::nih_sts_t sts,
  output nih_pkg::nih_cmd_t cmd
);

  localparam int unsigned ITER_W = $clog2(MAX_ITERATIONS + 1);

  nih_pkg::nih_state_t state_r, state_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic                at_limit;

  assign at_limit = (iter_r == ITER_W'(MAX_ITERATIONS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nih_pkg::ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    case (state_r)
      nih_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = nih_pkg::ST_MUL_X;
          iter_nxt  = '0;
        end
      end
      nih_pkg::ST_MUL_X: state_nxt = nih_pkg::ST_MUL_Y;
      nih_pkg::ST_MUL_Y: state_nxt = nih_pkg::ST_ADD;
      nih_pkg::ST_ADD:   state_nxt = nih_pkg::ST_CHECK;
      nih_pkg::ST_CHECK: begin
        if (sts.sq_zero || at_limit || sts.est_zero) begin
          state_nxt = nih_pkg::ST_DONE;
        end else begin
          state_nxt = nih_pkg::ST_DIV;
        end
      end
      nih_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = nih_pkg::ST_UPDATE;
        end
      end
      nih_pkg::ST_UPDATE: begin
        iter_nxt  = iter_r + 1'b1;
        state_nxt = sts.converged ? nih_pkg::ST_DONE : nih_pkg::ST_CHECK;
      end
      nih_pkg::ST_DONE: begin
        if (out_ready) begin
          state_nxt = nih_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nih_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      nih_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      nih_pkg::ST_MUL_X: cmd.mul_x = 1'b1;
      nih_pkg::ST_MUL_Y: cmd.mul_y = 1'b1;
      nih_pkg::ST_ADD:   cmd.add   = 1'b1;
      nih_pkg::ST_CHECK: begin
        if (sts.sq_zero) begin
          cmd.zero = 1'b1;
        end else if (!at_limit) begin
          if (sts.est_zero) begin
            cmd.fail = 1'b1;
          end else begin
            cmd.div_start = 1'b1;
          end
        end
      end
      nih_pkg::ST_DIV:    cmd.div_step = 1'b1;
      nih_pkg::ST_UPDATE: cmd.update   = 1'b1;
      nih_pkg::ST_DONE:   out_valid    = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/newton_integer_hypotenuse.sv @@
// ----------------------------------------------------------------------------
// newton_integer_hypotenuse: integer vector length by Newton iteration
// Sequence: after the input transaction the controller squares both offsets,
//   adds and checks; a zero vector or zero first estimate ends there, else
//   Newton steps run until convergence, a zero estimate or the step limit.
// Throughput: one transaction at a time; each step runs the bit-serial
//   divider at one quotient bit per cycle. Reset clears the controller only.
// ----------------------------------------------------------------------------
module newton_integer_hypotenuse #(
  parameter int unsigned MAX_ITERATIONS = 100   // 1 to 255
) (
  input  logic     clk,
  input  logic     rst_n,
  nih_in_if.sink   in_ch,
  nih_out_if.source out_ch
);

  nih_pkg::nih_cmd_t cmd;
  nih_pkg::nih_sts_t sts;

  // Controller: walks square -> check -> divide -> update until the estimate
  // repeats, hits zero, or the step limit runs out; then hold the result
  // until the sink takes it.
  nih_ctrl #(
    .MAX_ITERATIONS(MAX_ITERATIONS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: one squarer shared by both offsets, 32-step restoring divider
  // on magnitudes with the sign restored afterwards, 16-bit wrapping update.
  nih_dp u_dp (
    .clk     (clk),
    .offset_x(in_ch.offset_x),
    .offset_y(in_ch.offset_y),
    .cmd     (cmd),
    .sts     (sts),
    .length  (out_ch.length),
    .failed  (out_ch.failed)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
`include "assert_macros.svh"

  // the block works on one transaction at a time
  `ASSERT_IMPL(a_no_overlap, out_ch.valid, !in_ch.ready, "input ready while result pending")
  // a failed result always reports zero length
  `ASSERT_IMPL(a_fail_zero, out_ch.valid && out_ch.failed, out_ch.length == 16'sd0,
               "failed result with nonzero length")
  // a new transaction never shows a result in the next cycle
  `ASSERT_NEXT(a_no_instant, in_ch.valid && in_ch.ready, !out_ch.valid,
               "result valid right after input transaction")
  // the divider only starts on a nonzero estimate
  `ASSERT_IMPL(a_div_nonzero, cmd.div_start, !sts.est_zero, "divide by zero estimate")

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for newton_integer_hypotenuse
// Drives offset pairs into the input channel and computes the Newton length
// of each pair with an in-bench predictor that keeps the 32-bit and 16-bit
// wrap behavior. Each result transaction is checked in order against the
// oldest expected length. Both channel sides stall at random, except in the last phase.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned NEWTON_STEPS = 100;        // matches the block default
  localparam int unsigned DRAIN_CYCLES = 16;         // tail after the last result
  localparam int unsigned CYCLE_LIMIT  = 25_000_000; // hard cap on the whole run

  // One expected result, with the offsets that caused it for the error line.
  typedef struct {
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] length;
    logic               failed;
  } hyp_result_t;

  logic clk;
  logic rst_n;

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  hyp_result_t expected_lengths[$];

  nih_in_if  in_ch ();
  nih_out_if out_ch ();

  newton_integer_hypotenuse dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running clock, 10 time units per period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop: a hung handshake must not run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Predict one result: square sum wraps at 32 bits, the first estimate is
  // |x|+|y| cut to 16 bits, and each Newton step divides signed with
  // truncation, adds with a 16-bit wrap and halves toward zero.
  function automatic hyp_result_t predict_hypotenuse(input logic signed [15:0] x,
                                                     input logic signed [15:0] y);
    hyp_result_t        r;
    logic        [31:0] wide_x;
    logic        [31:0] wide_y;
    logic        [31:0] square;
    logic        [31:0] first_sum;
    logic        [31:0] divisor;
    logic        [31:0] mag_num;
    logic        [31:0] mag_den;
    logic        [31:0] quotient;
    logic        [15:0] step_sum;
    logic signed [15:0] estimate;
    logic signed [15:0] prev;
    int unsigned        step;
    wide_x    = {{16{x[15]}}, x};
    wide_y    = {{16{y[15]}}, y};
    square    = wide_x * wide_x + wide_y * wide_y;
    first_sum = (x[15] ? 32'd0 - wide_x : wide_x) + (y[15] ? 32'd0 - wide_y : wide_y);
    estimate  = first_sum[15:0];
    r.offset_x = x;
    r.offset_y = y;
    r.failed   = 1'b0;
    if (square == 32'd0) begin
      estimate = 16'sd0;
    end else begin
      for (step = 0; step < NEWTON_STEPS; step++) begin
        prev = estimate;
        if (prev == 16'sd0) begin
          r.failed = 1'b1;
          estimate = 16'sd0;
          break;
        end
        divisor  = {{16{prev[15]}}, prev};
        mag_num  = square[31] ? 32'd0 - square : square;
        mag_den  = prev[15] ? 32'd0 - divisor : divisor;
        quotient = mag_num / mag_den;
        // Negate on unlike signs; -2^31 / -1 wraps back to -2^31 this way.
        if (square[31] != prev[15]) quotient = 32'd0 - quotient;
        step_sum = divisor[15:0] + quotient[15:0];
        estimate = $signed(step_sum) / 16'sd2;
        if (estimate == prev) break;
      end
    end
    r.length = estimate;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Sink side: drop ready at random, once per falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Result checker: compare each accepted transaction with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    hyp_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_lengths.size() == 0) begin
        report_mismatch($sformatf("unexpected result length=%0d failed=%0b",
                                  out_ch.length, out_ch.failed));
      end else begin
        want = expected_lengths.pop_front();
        if (out_ch.length !== want.length)
          report_mismatch($sformatf("(%0d,%0d) length got %0d want %0d",
                                    want.offset_x, want.offset_y, out_ch.length, want.length));
        if (out_ch.failed !== want.failed)
          report_mismatch($sformatf("(%0d,%0d) failed got %0b want %0b",
                                    want.offset_x, want.offset_y, out_ch.failed, want.failed));
      end
    end
  end

  // Send one offset pair: idle for a random number of falling edges, then
  // hold valid and the payload until the block takes the transaction.
  task automatic send_offsets(input logic signed [15:0] x, input logic signed [15:0] y);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.offset_x <= x;
    in_ch.offset_y <= y;
    do @(posedge clk); while (!in_ch.ready);
    expected_lengths.push_back(predict_hypotenuse(x, y));
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  // Zero vector, axis and corner extremes, the negative square sum, first
  // estimates that wrap to zero or to negative, and a few exact squares.
  task automatic test_directed_offsets();
    send_offsets(16'sd0, 16'sd0);
    send_offsets(16'sd1, 16'sd0);
    send_offsets(16'sd0, -16'sd1);
    send_offsets(16'sd3, 16'sd4);
    send_offsets(-16'sd3, -16'sd4);
    send_offsets(16'sd24, -16'sd7);
    send_offsets(16'sd1, 16'sd1);
    send_offsets(16'sd2, 16'sd2);
    send_offsets(16'sd32767, 16'sd0);
    send_offsets(16'sd0, 16'sd32767);
    send_offsets(-16'sd32768, 16'sd0);
    send_offsets(16'sd0, -16'sd32768);
    send_offsets(16'sd32767, 16'sd32767);
    send_offsets(-16'sd32768, -16'sd32768);   // square reads as -2^31, estimate wraps to 0
    send_offsets(-16'sd32768, 16'sd32767);
    send_offsets(16'sd32767, -16'sd32768);
    send_offsets(-16'sd32768, -16'sd1);
    send_offsets(16'sd16384, 16'sd16384);      // estimate wraps to -32768
    send_offsets(-16'sd16384, 16'sd16384);
    send_offsets(16'sd100, 16'sd100);
    send_offsets(-16'sd1, -16'sd1);
  endtask

  // Offsets weighted toward the small values that converge fast, with full
  // range, near-wrap magnitudes and the extremes mixed in.
  function automatic logic signed [15:0] pick_offset();
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 16'($signed($urandom_range(0, 400)) - 200);
      4, 5, 6:    v = 16'($urandom);
      7: begin
        case ($urandom_range(0, 4))
          0:       v = -16'sd32768;
          1:       v = 16'sd32767;
          2:       v = -16'sd1;
          3:       v = 16'sd1;
          default: v = 16'sd0;
        endcase
      end
      8:       v = 16'($signed($urandom_range(0, 8000)) - 4000);
      default: v = 16'($urandom_range(16384, 32767)) * ($urandom_range(0, 1) ? -16'sd1 : 16'sd1);
    endcase
    return v;
  endfunction

  task automatic test_random_offsets(input int unsigned count);
    repeat (count) send_offsets(pick_offset(), pick_offset());
  endtask

  initial begin
    // Hold every input at a known value before the first edge.
    rst_n          = 1'b0;
    cycle_count    = 0;
    error_count    = 0;
    src_idle_pct   = 0;
    snk_idle_pct   = 0;
    in_ch.valid    = 1'b0;
    in_ch.offset_x = '0;
    in_ch.offset_y = '0;
    out_ch.ready   = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_idling(19, 50);
    test_directed_offsets();
    test_random_offsets(400);

    set_idling(50, 19);
    test_random_offsets(400);

    set_idling(0, 0);
    test_random_offsets(400);

    // Drop valid, then drain the outstanding results.
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_lengths.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/nih_pkg.sv
hw/rtl/nih_if.sv
hw/rtl/nih_dp.sv
hw/rtl/nih_ctrl.sv
hw/rtl/newton_integer_hypotenuse.sv
test/tb.sv
